// ===== sv/sset_pkg.sv =====
// Shared types and constants for the sorted set engine.
package sset_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 5;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_MEMBER = 3'd2,
    OP_MIN    = 3'd3,
    OP_MAX    = 3'd4,
    OP_XMIN   = 3'd5,
    OP_XMAX   = 3'd6
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] operand_value;
  } req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]        entry_total;
    logic signed [VALUE_W-1:0] result_value;
    logic                      success;
  } rsp_t;

endpackage

// ===== sv/sset_core.sv =====
// Sequencer, entry memory and shared comparator of the sorted set engine.
module sset_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sset_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sset_pkg::rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SCAN_CMP,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_PEEK,
    S_PEEK_CMP,
    S_DONE
  } state_t;

  state_t                              state;
  sset_pkg::op_t                       op;
  logic signed [sset_pkg::VALUE_W-1:0] operand;
  logic [sset_pkg::CNT_W-1:0]          idx;
  logic [sset_pkg::CNT_W-1:0]          slot;
  logic                                found;
  logic [sset_pkg::CNT_W-1:0]          occ;
  logic                                ok;
  logic signed [sset_pkg::VALUE_W-1:0] res;

  logic [sset_pkg::VALUE_W-1:0] mem [sset_pkg::CAPACITY];
  logic [sset_pkg::VALUE_W-1:0] rdata;
  logic [sset_pkg::IDX_W-1:0]   raddr;
  logic [sset_pkg::IDX_W-1:0]   waddr;
  logic [sset_pkg::VALUE_W-1:0] wdata;
  logic                         we;

  logic [sset_pkg::CNT_W-1:0] idx_inc;
  logic [sset_pkg::CNT_W-1:0] idx_dec;
  logic [sset_pkg::CNT_W-1:0] occ_dec;
  logic                       cmp_lt;
  logic                       cmp_eq;

  assign idx_inc = idx + sset_pkg::CNT_W'(1);
  assign idx_dec = idx - sset_pkg::CNT_W'(1);
  assign occ_dec = occ - sset_pkg::CNT_W'(1);

  // The one comparator, shared by every step of the search.
  assign cmp_lt = $signed(rdata) < operand;
  assign cmp_eq = rdata == operand;

  always_comb begin
    raddr = idx[sset_pkg::IDX_W-1:0];
    waddr = idx[sset_pkg::IDX_W-1:0];
    wdata = rdata;
    we    = 1'b0;
    case (state)
      S_UP_RD: begin
        raddr = idx_dec[sset_pkg::IDX_W-1:0];
        if (idx == slot) begin
          we    = 1'b1;
          waddr = slot[sset_pkg::IDX_W-1:0];
          wdata = operand;
        end
      end
      S_UP_WR: we = 1'b1;
      S_DN_RD: raddr = idx_inc[sset_pkg::IDX_W-1:0];
      S_DN_WR: we = 1'b1;
      S_PEEK: begin
        if (op inside {sset_pkg::OP_MIN, sset_pkg::OP_XMIN}) begin
          raddr = '0;
        end else begin
          raddr = occ_dec[sset_pkg::IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.op;
            operand <= req.operand_value;
            ok      <= 1'b0;
            res     <= '0;
            state   <= S_START;
          end
        end
        S_START: begin
          if (op inside {sset_pkg::OP_INSERT, sset_pkg::OP_REMOVE, sset_pkg::OP_MEMBER}) begin
            idx   <= '0;
            state <= S_SCAN;
          end else if (op inside {sset_pkg::OP_MIN, sset_pkg::OP_MAX,
                                  sset_pkg::OP_XMIN, sset_pkg::OP_XMAX}) begin
            state <= (occ == '0) ? S_DONE : S_PEEK;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (idx == occ) begin
            found <= 1'b0;
            slot  <= idx;
            state <= S_DECIDE;
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (cmp_lt) begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end else begin
            found <= cmp_eq;
            slot  <= idx;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          case (op)
            sset_pkg::OP_MEMBER: begin
              ok    <= found;
              state <= S_DONE;
            end
            sset_pkg::OP_INSERT: begin
              if (found || occ == sset_pkg::CNT_W'(sset_pkg::CAPACITY)) begin
                state <= S_DONE;
              end else begin
                idx   <= occ;
                state <= S_UP_RD;
              end
            end
            sset_pkg::OP_REMOVE: begin
              if (!found) begin
                state <= S_DONE;
              end else begin
                idx   <= slot;
                state <= S_DN_RD;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_UP_RD: begin
          // Reaching the slot means the new value is written there in this same cycle.
          if (idx == slot) begin
            occ   <= occ + sset_pkg::CNT_W'(1);
            ok    <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          idx   <= idx_dec;
          state <= S_UP_RD;
        end
        S_DN_RD: begin
          if (idx_inc >= occ) begin
            occ   <= occ_dec;
            ok    <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          idx   <= idx_inc;
          state <= S_DN_RD;
        end
        S_PEEK: state <= S_PEEK_CMP;
        S_PEEK_CMP: begin
          ok  <= 1'b1;
          res <= rdata;
          if (op == sset_pkg::OP_XMIN) begin
            idx   <= '0;
            state <= S_DN_RD;
          end else if (op == sset_pkg::OP_XMAX) begin
            occ   <= occ_dec;
            state <= S_DONE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready        = state == S_IDLE;
  assign rsp_valid        = state == S_DONE;
  assign rsp.success      = ok;
  assign rsp.result_value = res;
  assign rsp.entry_total  = sset_pkg::TOTAL_W'(occ);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= sset_pkg::CNT_W'(sset_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (occ == $past(occ)) || (occ == $past(occ) + sset_pkg::CNT_W'(1))
             || (occ == $past(occ) - sset_pkg::CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !we)
    else $error("memory written outside an operation");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.success) |-> (rsp.result_value == '0))
    else $error("failed transaction carries a nonzero value");

endmodule

// ===== sv/sorted_set_engine_unit.sv =====
// Top level of the sorted set engine: stream ports and result register.
//
//  channel | direction | transaction carries
//  s_*     | in        | one request: op, operand_value
//  m_*     | out       | one result: success, result_value, entry_total
//
// A request is taken only while the sequencer is idle, and the sequencer then
// walks the entry memory through one read port with one shared comparator.
// The linear search takes a read and a compare per entry below the operand; an
// insert or remove then takes a read and a write per entry shifted, so the
// cheapest request is a read on an empty set or the unused op code and the
// costliest an insert at the front of a set of 15 or a remove from a full set,
// and the sequencer passes through idle before it takes the next request.
// Reset clears the entry count and the sequencer; the memory needs no clearing.
// A finished result sits in the output register; a stall on m_tready holds it while the
// sequencer takes the next request, whose result then waits until the register drains.
module sorted_set_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // op[2:0], operand_value[34:3], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // success[0], result_value[32:1], entry_total[37:33], pad
);

  sset_pkg::req_t req;
  sset_pkg::rsp_t rsp;
  sset_pkg::rsp_t out_rsp;
  logic           rsp_valid;
  logic           rsp_ready;
  logic           out_valid;

  assign req.op            = sset_pkg::op_t'(s_tdata[2:0]);
  assign req.operand_value = s_tdata[34:3];

  sset_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // The output register accepts a new result when empty or being drained.
  assign rsp_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        out_valid <= 1'b1;
        out_rsp   <= rsp;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_rsp};

endmodule

// ===== tb/sv/sset_response_checker.sv =====
`timescale 1ns / 1ps
// Channel monitor for the sorted set engine: models the set and compares every reply.
module sset_response_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // op[2:0], operand_value[34:3], zero pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // success[0], result_value[32:1], entry_total[37:33], pad
  output int          mismatch_count,
  output int          replies_owed
);

  // Model of the set: keys in ascending signed order, only the first set_size valid.
  logic signed [sset_pkg::VALUE_W-1:0] set_keys [sset_pkg::CAPACITY];
  int                                  set_size;
  sset_pkg::rsp_t                      expected_replies [$];
  sset_pkg::rsp_t                      want_reply;
  sset_pkg::rsp_t                      got_reply;
  int                                  fail_tally;

  task automatic report_mismatch(input string what, input logic [37:0] want_bits,
                                 input logic [37:0] got_bits);
    $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, want_bits, got_bits);
    fail_tally++;
  endtask

  function automatic void drop_key(input int slot);
    for (int i = slot; i + 1 < set_size; i++) begin
      set_keys[i] = set_keys[i + 1];
    end
    set_size--;
  endfunction

  // Applies one request to the model and returns the reply it must produce.
  function automatic sset_pkg::rsp_t apply_set_request(
      input logic [2:0] op, input logic signed [sset_pkg::VALUE_W-1:0] key);
    sset_pkg::rsp_t reply;
    int             slot;
    bit             found;
    reply = '0;
    slot  = 0;
    while (slot < set_size && set_keys[slot] < key) begin
      slot++;
    end
    found = (slot < set_size) && (set_keys[slot] == key);
    case (op)
      sset_pkg::OP_INSERT: begin
        if (!found && set_size < sset_pkg::CAPACITY) begin
          for (int i = set_size; i > slot; i--) begin
            set_keys[i] = set_keys[i - 1];
          end
          set_keys[slot] = key;
          set_size++;
          reply.success = 1'b1;
        end
      end
      sset_pkg::OP_REMOVE: begin
        if (found) begin
          drop_key(slot);
          reply.success = 1'b1;
        end
      end
      sset_pkg::OP_MEMBER: begin
        reply.success = found;
      end
      sset_pkg::OP_MIN, sset_pkg::OP_XMIN: begin
        if (set_size > 0) begin
          reply.result_value = set_keys[0];
          reply.success      = 1'b1;
          if (op == sset_pkg::OP_XMIN) begin
            drop_key(0);
          end
        end
      end
      sset_pkg::OP_MAX, sset_pkg::OP_XMAX: begin
        if (set_size > 0) begin
          reply.result_value = set_keys[set_size - 1];
          reply.success      = 1'b1;
          if (op == sset_pkg::OP_XMAX) begin
            set_size--;
          end
        end
      end
      default: begin
      end
    endcase
    reply.entry_total = sset_pkg::TOTAL_W'(set_size);
    return reply;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      set_size   = 0;
      fail_tally = 0;
      expected_replies.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_replies.push_back(apply_set_request(s_tdata[2:0], s_tdata[34:3]));
      end
      if (m_tvalid && m_tready) begin
        got_reply = sset_pkg::rsp_t'(m_tdata[37:0]);
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no request outstanding", '0, got_reply);
        end else begin
          want_reply = expected_replies.pop_front();
          if (got_reply.success !== want_reply.success) begin
            report_mismatch("success", 38'(want_reply.success), 38'(got_reply.success));
          end
          if (got_reply.result_value !== want_reply.result_value) begin
            report_mismatch("result_value", 38'(want_reply.result_value),
                            38'(got_reply.result_value));
          end
          if (got_reply.entry_total !== want_reply.entry_total) begin
            report_mismatch("entry_total", 38'(want_reply.entry_total),
                            38'(got_reply.entry_total));
          end
        end
      end
    end
    replies_owed   <= expected_replies.size();
    mismatch_count <= fail_tally;
  end

endmodule

// ===== tb/sv/sorted_set_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// Top of the sorted set engine testbench: clock, reset, request traffic and verdict.
module sorted_set_engine_unit_tb;

  // The block takes a request only when its sequencer is idle, and one request may
  // walk and shift the whole entry memory. The quiet limit covers that, the long
  // receiver hold-off and the random stalls on both sides several times over.
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_CYCLES     = 400;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int POOL_SIZE       = 24;
  localparam int DRAIN_CYCLES    = 100;

  // The op field has room for one code that the block does not define.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // op[2:0], operand_value[34:3], zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // success[0], result_value[32:1], entry_total[37:33], pad

  int mismatch_count;
  int replies_owed;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  int fill_pct;
  bit hold_request;
  bit hold_done;

  // Values that random requests mostly draw from, so that inserts collide,
  // removes and membership tests hit, and the set actually fills up.
  logic signed [sset_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];

  sorted_set_engine_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sset_response_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .replies_owed   (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one request at a falling edge, after a random number of idle cycles,
  // and holds it until the block takes it. It returns at the falling edge after
  // the transaction with s_tvalid still high, so that back-to-back requests
  // never lower and raise the valid in one time step.
  task automatic offer_request(input logic [2:0] op,
                               input logic [sset_pkg::VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, value, op};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Fresh pool per phase: the four extremes always, the rest a mix of small
  // numbers near zero and full-range random patterns.
  task automatic refresh_pool();
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int k = 4; k < POOL_SIZE; k++) begin
      if (k % 2 == 0) begin
        value_pool[k] = $signed($urandom_range(40)) - 20;
      end else begin
        value_pool[k] = $urandom;
      end
    end
  endtask

  function automatic logic [sset_pkg::VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 75) begin
      return value_pool[$urandom_range(POOL_SIZE - 1)];
    end
    return $urandom;
  endfunction

  // Inserts get the weight given; the other six operations share the rest evenly.
  function automatic logic [2:0] pick_op(input int insert_pct);
    int roll;
    if ($urandom_range(99) < insert_pct) begin
      return sset_pkg::OP_INSERT;
    end
    roll = $urandom_range(5);
    case (roll)
      0:       return sset_pkg::OP_REMOVE;
      1:       return sset_pkg::OP_MEMBER;
      2:       return sset_pkg::OP_MIN;
      3:       return sset_pkg::OP_MAX;
      4:       return sset_pkg::OP_XMIN;
      default: return sset_pkg::OP_XMAX;
    endcase
  endfunction

  // Receiver side. It normally drops m_tready at random; when a hold-off is
  // requested it keeps m_tready low for a long counted stretch so that the
  // result register fills and the block has to stall its request channel.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
        end
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any cycle with a transaction on either channel resets the count.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    hold_request  = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 54;
    fill_pct      = 50;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The set starts empty, so reads, extracts and removes all
    // fail with a zero value; the undefined op code must leave the set alone.
    offer_request(sset_pkg::OP_MIN, $urandom);
    offer_request(sset_pkg::OP_XMAX, $urandom);
    offer_request(sset_pkg::OP_REMOVE, 32'h0000_0000);
    offer_request(OP_UNUSED, $urandom);

    // Fill to capacity, mostly in descending order so that each insert lands
    // at the front and shifts every stored entry.
    offer_request(sset_pkg::OP_INSERT, 32'h7FFF_FFFF);
    for (int k = 0; k < 13; k++) begin
      offer_request(sset_pkg::OP_INSERT, 32'h7000_0000 - k * 32'h1111_1111);
    end
    offer_request(sset_pkg::OP_INSERT, 32'h0000_0000);
    offer_request(sset_pkg::OP_INSERT, 32'h8000_0000);

    // Full set: a duplicate and a new value are both refused. Then membership,
    // a remove of an absent value, both reads, both extracts, and a remove
    // of a value from the middle.
    offer_request(sset_pkg::OP_INSERT, 32'h0000_0000);
    offer_request(sset_pkg::OP_INSERT, 32'hFFFF_FFFF);
    offer_request(sset_pkg::OP_MEMBER, 32'h7FFF_FFFF);
    offer_request(sset_pkg::OP_REMOVE, 32'h0000_0005);
    offer_request(sset_pkg::OP_MIN, $urandom);
    offer_request(sset_pkg::OP_MAX, $urandom);
    offer_request(sset_pkg::OP_XMIN, $urandom);
    offer_request(sset_pkg::OP_XMAX, $urandom);
    offer_request(sset_pkg::OP_REMOVE, 32'h0000_0000);

    // Random part in three phases of stall pattern. Within each phase the
    // traffic swings between insert-heavy stretches that fill the set and
    // drain-heavy stretches that empty it, so full and empty both recur.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      refresh_pool();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 75 == 0) begin
          fill_pct = ((n / 75) % 2 == 0) ? 65 : 20;
        end
        // With neither side idling, one long receiver hold-off while the
        // requests keep coming.
        if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
          hold_request = 1'b1;
        end
        offer_request(pick_op(fill_pct), pick_value());
      end
    end
    s_tvalid <= 1'b0;

    // Wait for every reply, then a little longer so that a stray extra reply
    // would still be caught.
    while (replies_owed != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
